// ----- rtl/core/framebuffer_scroll_rotate_engine_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the framebuffer scroll/rotate engine core.
// Each macro expands to a concurrent assertion in simulation and to
// nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef FRAMEBUFFER_SCROLL_ROTATE_ENGINE_CORE_MACROS_SVH
`define FRAMEBUFFER_SCROLL_ROTATE_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define FSRE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fsre assertion failed");
// antecedent implies consequent in the next cycle
`define FSRE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fsre assertion failed");
`else
`define FSRE_ASSERT_SAME(label, clk, rstn, ante, cons)
`define FSRE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/fsre_pkg.sv -----
// ---------------------------------------------------------------------------
// fsre_pkg
// Shared constants, command codes and types of the scroll/rotate engine.
// ---------------------------------------------------------------------------
`default_nettype none
package fsre_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int PIXEL_BITS = 24;
    localparam int XB         = $clog2(MAX_WIDTH);
    localparam int YB         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = XB + YB;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int SC_W       = 10;  // signed coordinate, covers -512..511
    localparam int DIM_W      = 7;
    localparam int CNT_W      = 6;

    localparam logic [3:0] OP_WRITE     = 4'd0;
    localparam logic [3:0] OP_READ      = 4'd1;
    localparam logic [3:0] OP_FILL      = 4'd2;
    localparam logic [3:0] OP_FILL_ROW  = 4'd3;
    localparam logic [3:0] OP_FILL_COL  = 4'd4;
    localparam logic [3:0] OP_COPY_ROW  = 4'd5;
    localparam logic [3:0] OP_COPY_COL  = 4'd6;
    localparam logic [3:0] OP_ROT_L     = 4'd7;
    localparam logic [3:0] OP_ROT_R     = 4'd8;
    localparam logic [3:0] OP_ROT_U     = 4'd9;
    localparam logic [3:0] OP_ROT_D     = 4'd10;
    localparam logic [3:0] OP_SHIFT_L   = 4'd11;
    localparam logic [3:0] OP_SHIFT_R   = 4'd12;
    localparam logic [3:0] OP_SHIFT_U   = 4'd13;
    localparam logic [3:0] OP_SHIFT_D   = 4'd14;
    localparam logic [3:0] OP_UNUSED    = 4'd15;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG     = 2'd2;

    typedef struct packed {
        logic [3:0]       op;
        logic [7:0]       x;
        logic [7:0]       y;
        logic [7:0]       n;
        logic [7:0]       src;
        logic [7:0]       dst;
        logic [DIM_W-1:0] xf;
        logic [DIM_W-1:0] yf;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [CNT_W-1:0] in_last;
        logic [CNT_W-1:0] out_last;
    } cmd_t;

    typedef struct packed {
        logic signed [SC_W-1:0] sx;
        logic signed [SC_W-1:0] sy;
        logic signed [SC_W-1:0] dx;
        logic signed [SC_W-1:0] dy;
        logic signed [SC_W-1:0] tx;
        logic signed [SC_W-1:0] ty;
        logic                   use_tmp;
        logic                   use_color;
        logic                   wen;
        logic                   clr_src;
    } step_t;

    function automatic logic on_canvas(input logic signed [SC_W-1:0] px,
                                       input logic signed [SC_W-1:0] py,
                                       input logic [DIM_W-1:0] w,
                                       input logic [DIM_W-1:0] h);
        logic signed [SC_W-1:0] ws;
        logic signed [SC_W-1:0] hs;
        ws = $signed({{(SC_W-DIM_W){1'b0}}, w});
        hs = $signed({{(SC_W-DIM_W){1'b0}}, h});
        return (px >= 0) && (py >= 0) && (px < ws) && (py < hs);
    endfunction

    function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [SC_W-1:0] px,
                                                   input logic signed [SC_W-1:0] py);
        return {py[YB-1:0], px[XB-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fsre_step_gen.sv -----
// ---------------------------------------------------------------------------
// fsre_step_gen
// Maps the current command and its inner/outer counters to the source,
// destination and line-start coordinates of one pixel move.
// ---------------------------------------------------------------------------
`default_nettype none
module fsre_step_gen
    import fsre_pkg::*;
(
    input  cmd_t             cmd,
    input  logic [CNT_W-1:0] k,
    input  logic [CNT_W-1:0] o,
    output step_t            step
);

    logic signed [SC_W-1:0] kk, oo, xs, ys, ns, srcs, dsts, ws, hs, xfs, yfs, si, sj;

    always_comb begin
        kk   = $signed({{(SC_W-CNT_W){1'b0}}, k});
        oo   = $signed({{(SC_W-CNT_W){1'b0}}, o});
        xs   = $signed({2'b00, cmd.x});
        ys   = $signed({2'b00, cmd.y});
        ns   = $signed({2'b00, cmd.n});
        srcs = $signed({2'b00, cmd.src});
        dsts = $signed({2'b00, cmd.dst});
        ws   = $signed({{(SC_W-DIM_W){1'b0}}, cmd.w});
        hs   = $signed({{(SC_W-DIM_W){1'b0}}, cmd.h});
        xfs  = $signed({{(SC_W-DIM_W){1'b0}}, cmd.xf});
        yfs  = $signed({{(SC_W-DIM_W){1'b0}}, cmd.yf});
        si   = (cmd.op == OP_SHIFT_R) ? (xfs - 10'sd1 - oo) : (xs + oo);
        sj   = (cmd.op == OP_SHIFT_D) ? (yfs - 10'sd1 - kk) : (ys + kk);

        step = '0;
        step.use_tmp = (k == cmd.in_last);
        case (cmd.op)
            OP_WRITE: begin
                step.dx = xs; step.dy = ys; step.wen = 1'b1; step.use_color = 1'b1;
            end
            OP_READ: begin
                step.sx = xs; step.sy = ys;
            end
            OP_FILL: begin
                step.dx = kk; step.dy = oo; step.wen = 1'b1; step.use_color = 1'b1;
            end
            OP_FILL_ROW: begin
                step.dx = kk; step.dy = ys; step.wen = 1'b1; step.use_color = 1'b1;
            end
            OP_FILL_COL: begin
                step.dx = xs; step.dy = kk; step.wen = 1'b1; step.use_color = 1'b1;
            end
            OP_COPY_ROW: begin
                step.sx = kk; step.sy = srcs; step.dx = kk; step.dy = dsts;
                step.wen = 1'b1;
            end
            OP_COPY_COL: begin
                step.sx = srcs; step.sy = kk; step.dx = dsts; step.dy = kk;
                step.wen = 1'b1;
            end
            OP_ROT_L: begin
                step.sx = kk + 10'sd1; step.sy = oo; step.dx = kk; step.dy = oo;
                step.tx = '0; step.ty = oo; step.wen = 1'b1;
            end
            OP_ROT_R: begin
                step.sx = ws - 10'sd2 - kk; step.sy = oo;
                step.dx = ws - 10'sd1 - kk; step.dy = oo;
                step.tx = ws - 10'sd1; step.ty = oo; step.wen = 1'b1;
            end
            OP_ROT_U: begin
                // row y takes the old row y-1, last row wraps to row 0
                step.sx = oo; step.sy = hs - 10'sd2 - kk;
                step.dx = oo; step.dy = hs - 10'sd1 - kk;
                step.tx = oo; step.ty = hs - 10'sd1; step.wen = 1'b1;
            end
            OP_ROT_D: begin
                step.sx = oo; step.sy = kk + 10'sd1; step.dx = oo; step.dy = kk;
                step.tx = oo; step.ty = '0; step.wen = 1'b1;
            end
            OP_SHIFT_L: begin
                step.sx = si; step.sy = sj; step.dx = si - ns; step.dy = sj;
                step.wen = 1'b1; step.clr_src = 1'b1; step.use_tmp = 1'b0;
            end
            OP_SHIFT_R: begin
                step.sx = si; step.sy = sj; step.dx = si + ns; step.dy = sj;
                step.wen = 1'b1; step.clr_src = 1'b1; step.use_tmp = 1'b0;
            end
            OP_SHIFT_U: begin
                step.sx = si; step.sy = sj; step.dx = si; step.dy = sj - ns;
                step.wen = 1'b1; step.clr_src = 1'b1; step.use_tmp = 1'b0;
            end
            OP_SHIFT_D: begin
                step.sx = si; step.sy = sj; step.dx = si; step.dy = sj + ns;
                step.wen = 1'b1; step.clr_src = 1'b1; step.use_tmp = 1'b0;
            end
            default: begin
                step = '0;
            end
        endcase
        // only rotations finish a line from the held first pixel
        if (!(cmd.op == OP_ROT_L || cmd.op == OP_ROT_R || cmd.op == OP_ROT_U ||
              cmd.op == OP_ROT_D)) begin
            step.use_tmp = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/framebuffer_scroll_rotate_engine_core.sv -----
// ---------------------------------------------------------------------------
// framebuffer_scroll_rotate_engine_core
// Pixel canvas in a 4096 x 24 synchronous RAM with a command sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on s_* (valid/ready), one result per request leaves on
//   m_* (valid/ready). Registers (width, height, background) are written
//   through cfg_* while no request is in flight, a rule on the user that
//   the block itself does not enforce; cfg_ready is always high.
//   Every pixel move is a RAM read, then a write-back; shifts add a step
//   that writes the background to the vacated source pixel, and rotations
//   first fetch each line's first pixel to hold it (ST_PRE, ST_TMP).
//   Shifts move only the part of the region clipped to the canvas.
//   The single RAM port pair serves all moves; one request runs at a time.
//   After reset a clearing pass writes zero to all 4096 entries, one a
//   cycle, with s_ready low. A finished result waits in the output register
//   while the receiver stalls; the next request is taken meanwhile, but
//   its result holds until the register is free.
// ---------------------------------------------------------------------------
`default_nettype none
`include "framebuffer_scroll_rotate_engine_core_macros.svh"
module framebuffer_scroll_rotate_engine_core
    import fsre_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [23:0]      cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [3:0]       s_req_type,
    input  wire logic [7:0]       s_x_pos,
    input  wire logic [7:0]       s_y_pos,
    input  wire logic [23:0]      s_pixel_color,
    input  wire logic [7:0]       s_region_width,
    input  wire logic [7:0]       s_region_height,
    input  wire logic [7:0]       s_shift_amount,
    input  wire logic [7:0]       s_line_src,
    input  wire logic [7:0]       s_line_dst,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [23:0]           m_read_color,
    output logic                  m_write_ok
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_PRE   = 8'b0000_0100,
        ST_TMP   = 8'b0000_1000,
        ST_RD    = 8'b0001_0000,
        ST_WR    = 8'b0010_0000,
        ST_CLR   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [DIM_W-1:0]      width_reg, width_next, height_reg, height_next;
    logic [PIXEL_BITS-1:0] bg_reg, bg_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PIXEL_BITS-1:0] color_reg, color_next, tmp_reg, tmp_next;
    logic [CNT_W-1:0]      k_reg, k_next, o_reg, o_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic                  src_in_reg, src_in_next;
    logic [23:0]           rc_reg, rc_next;
    logic                  ok_reg, ok_next;
    logic                  m_valid_reg, m_valid_next;
    logic [23:0]           m_color_reg, m_color_next;
    logic                  m_ok_reg, m_ok_next;

    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata;

    step_t                 step;
    logic                  src_in, dst_in, is_rot, is_shift, last_k, last_o;
    logic [DIM_W-1:0]      w_eff, h_eff, xf_c, yf_c;
    logic [8:0]            xsum, ysum;
    logic [PIXEL_BITS-1:0] wr_val;

    fsre_step_gen u_step (
        .cmd  (cmd_reg),
        .k    (k_reg),
        .o    (o_reg),
        .step (step)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    always_comb begin
        w_eff = (width_reg == '0) ? 7'd1 :
                (width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg == '0) ? 7'd1 :
                (height_reg > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_reg;
        xsum  = {1'b0, s_x_pos} + {1'b0, s_region_width};
        ysum  = {1'b0, s_y_pos} + {1'b0, s_region_height};
        xf_c  = (xsum > {2'b00, w_eff}) ? w_eff : xsum[DIM_W-1:0];
        yf_c  = (ysum > {2'b00, h_eff}) ? h_eff : ysum[DIM_W-1:0];
    end

    assign is_rot   = (cmd_reg.op == OP_ROT_L) || (cmd_reg.op == OP_ROT_R) ||
                      (cmd_reg.op == OP_ROT_U) || (cmd_reg.op == OP_ROT_D);
    assign is_shift = (s_req_type == OP_SHIFT_L) || (s_req_type == OP_SHIFT_R) ||
                      (s_req_type == OP_SHIFT_U) || (s_req_type == OP_SHIFT_D);
    assign src_in   = on_canvas(step.sx, step.sy, cmd_reg.w, cmd_reg.h);
    assign dst_in   = on_canvas(step.dx, step.dy, cmd_reg.w, cmd_reg.h);
    assign last_k   = (k_reg == cmd_reg.in_last);
    assign last_o   = (o_reg == cmd_reg.out_last);
    assign wr_val   = step.use_tmp   ? tmp_reg :
                      step.use_color ? color_reg :
                      src_in_reg     ? mem_rdata : bg_reg;

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_read_color = m_color_reg;
    assign m_write_ok   = m_ok_reg;

    always_comb begin
        state_next   = state_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bg_next      = bg_reg;
        cmd_next     = cmd_reg;
        color_next   = color_reg;
        tmp_next     = tmp_reg;
        k_next       = k_reg;
        o_next       = o_reg;
        clr_next     = clr_reg;
        src_in_next  = src_in_reg;
        rc_next      = rc_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_color_next = m_color_reg;
        m_ok_next    = m_ok_reg;
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = pix_addr(step.dx, step.dy);
        mem_wdata    = wr_val;
        mem_re       = 1'b0;
        mem_raddr    = pix_addr(step.sx, step.sy);

        if (cfg_valid) begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_next = cfg_data[DIM_W-1:0];
                REG_BG:     bg_next     = cfg_data[PIXEL_BITS-1:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next.op   = s_req_type;
                    cmd_next.x    = s_x_pos;
                    cmd_next.y    = s_y_pos;
                    cmd_next.n    = s_shift_amount;
                    cmd_next.src  = s_line_src;
                    cmd_next.dst  = s_line_dst;
                    cmd_next.xf   = xf_c;
                    cmd_next.yf   = yf_c;
                    cmd_next.w    = w_eff;
                    cmd_next.h    = h_eff;
                    color_next    = s_pixel_color;
                    k_next        = '0;
                    o_next        = '0;
                    rc_next       = '0;
                    ok_next       = 1'b1;
                    state_next    = ST_RD;
                    case (s_req_type)
                        OP_FILL: begin
                            cmd_next.in_last  = CNT_W'(w_eff - 7'd1);
                            cmd_next.out_last = CNT_W'(h_eff - 7'd1);
                        end
                        OP_FILL_ROW, OP_COPY_ROW: begin
                            cmd_next.in_last  = CNT_W'(w_eff - 7'd1);
                            cmd_next.out_last = '0;
                        end
                        OP_FILL_COL, OP_COPY_COL: begin
                            cmd_next.in_last  = CNT_W'(h_eff - 7'd1);
                            cmd_next.out_last = '0;
                        end
                        OP_ROT_L, OP_ROT_R: begin
                            cmd_next.in_last  = CNT_W'(w_eff - 7'd1);
                            cmd_next.out_last = CNT_W'(h_eff - 7'd1);
                            state_next        = ST_PRE;
                        end
                        OP_ROT_U, OP_ROT_D: begin
                            cmd_next.in_last  = CNT_W'(h_eff - 7'd1);
                            cmd_next.out_last = CNT_W'(w_eff - 7'd1);
                            state_next        = ST_PRE;
                        end
                        default: begin
                            cmd_next.in_last  = '0;
                            cmd_next.out_last = '0;
                        end
                    endcase
                    if (is_shift) begin
                        cmd_next.in_last  = CNT_W'(yf_c - s_y_pos[DIM_W-1:0] - 7'd1);
                        cmd_next.out_last = CNT_W'(xf_c - s_x_pos[DIM_W-1:0] - 7'd1);
                        // region starting outside the clip does nothing
                        if ({1'b0, s_x_pos} >= {2'b00, xf_c} ||
                            {1'b0, s_y_pos} >= {2'b00, yf_c}) begin
                            state_next = ST_FIN;
                        end
                    end
                    if (s_req_type == OP_UNUSED) begin
                        ok_next    = 1'b0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_PRE: begin
                // fetch the line's first pixel before it gets overwritten
                mem_re     = 1'b1;
                mem_raddr  = pix_addr(step.tx, step.ty);
                state_next = ST_TMP;
            end
            ST_TMP: begin
                tmp_next   = mem_rdata;
                state_next = ST_RD;
            end
            ST_RD: begin
                mem_re      = src_in;
                src_in_next = src_in;
                state_next  = ST_WR;
            end
            ST_WR, ST_CLR: begin
                if (state_reg == ST_WR) begin
                    mem_we = step.wen && dst_in;
                    if (cmd_reg.op == OP_READ) begin
                        rc_next = src_in_reg ? mem_rdata : bg_reg;
                        ok_next = src_in_reg;
                    end
                    if (cmd_reg.op == OP_WRITE) begin
                        ok_next = dst_in;
                    end
                end else begin
                    // leave background behind the moved pixel
                    mem_we    = 1'b1;
                    mem_waddr = pix_addr(step.sx, step.sy);
                    mem_wdata = bg_reg;
                end
                if (state_reg == ST_WR && step.clr_src) begin
                    state_next = ST_CLR;
                end else if (!last_k) begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RD;
                end else if (!last_o) begin
                    k_next     = '0;
                    o_next     = o_reg + 1'b1;
                    state_next = is_rot ? ST_PRE : ST_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_color_next = rc_reg;
                    m_ok_next    = ok_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            width_reg   <= 7'(MAX_WIDTH);
            height_reg  <= 7'(MAX_HEIGHT);
            bg_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bg_reg      <= bg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        color_reg   <= color_next;
        tmp_reg     <= tmp_next;
        k_reg       <= k_next;
        o_reg       <= o_next;
        src_in_reg  <= src_in_next;
        rc_reg      <= rc_next;
        ok_reg      <= ok_next;
        m_color_reg <= m_color_next;
        m_ok_reg    <= m_ok_next;
    end

    `FSRE_ASSERT_SAME(a_wr_on_canvas, aclk, aresetn, (state_reg == ST_WR) && mem_we, dst_in)
    `FSRE_ASSERT_NEXT(a_rd_then_wr, aclk, aresetn, state_reg == ST_RD, state_reg == ST_WR)
    `FSRE_ASSERT_NEXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FSRE_ASSERT_NEXT(a_fin_emits, aclk, aresetn, (state_reg == ST_FIN) && !m_valid_reg, m_valid_reg)

endmodule
`default_nettype wire
